>>> design/substring_first_match_finder_macros.svh
// Assertion macros shared by the substring finder RTL.
`ifndef SUBSTRING_FIRST_MATCH_FINDER_MACROS_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sfmf_pkg.sv
// Shared types, constants and helpers for the substring finder.
package sfmf_pkg;

    localparam int DATA_W      = 8;
    localparam int PAT_BYTES   = 16;           // bytes held by the pattern registers
    localparam int LEN_W       = 5;            // pattern_length register width
    localparam int POS_W       = 16;           // match_position width
    localparam int CFG_DW      = 64;
    localparam int CFG_AW      = 5;
    localparam int OUT_TDATA_W = 24;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_MAX_BUFFER_BYTES  = 65536;

    localparam logic [DATA_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [DATA_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [DATA_W-1:0] CASE_OFFSET  = 8'h20;

    // Register map, by index (byte address is 8 * index).
    typedef enum logic [1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_IGNORE_CASE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PAT_BYTES*DATA_W-1:0] pattern;
        logic [LEN_W-1:0]            length;
        logic                        ignore_case;
    } t_cfg;

    // Fold a-z to A-Z when enabled; every other byte passes unchanged.
    function automatic logic [DATA_W-1:0] fold_byte(input logic [DATA_W-1:0] b,
                                                    input logic en);
        logic [DATA_W-1:0] r;
        r = b;
        if (en && b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
            r = b - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> design/sfmf_cell.sv
// One window cell: holds a byte, passes it on, compares the incoming byte.
module sfmf_cell
    import sfmf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_byte,
    input  logic [DATA_W-1:0] i_expect,   // already folded
    input  logic              i_active,
    input  logic              i_fold,
    output logic [DATA_W-1:0] o_byte,
    output logic              o_hit
);

    logic [DATA_W-1:0] r_byte;
    logic [DATA_W-1:0] n_byte;

    assign n_byte = i_shift ? i_byte : r_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    // compare against the byte this cell holds after the shift
    assign o_hit  = !i_active || (fold_byte(i_byte, i_fold) == i_expect);

endmodule

>>> design/sfmf_regs.sv
// APB configuration registers of the substring finder.
module sfmf_regs
    import sfmf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [CFG_DW-1:0] r_pat_lo;
    logic [CFG_DW-1:0] r_pat_hi;
    logic [LEN_W-1:0]  r_len;
    logic              r_icase;
    logic              w_wr;
    t_reg_idx          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= '0;
            r_icase  <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                REG_PATTERN_LOW:  r_pat_lo <= pwdata;
                REG_PATTERN_HIGH: r_pat_hi <= pwdata;
                REG_PATTERN_LEN:  r_len    <= pwdata[LEN_W-1:0];
                REG_IGNORE_CASE:  r_icase  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PATTERN_LOW:  prdata = r_pat_lo;
            REG_PATTERN_HIGH: prdata = r_pat_hi;
            REG_PATTERN_LEN:  prdata = CFG_DW'(r_len);
            REG_IGNORE_CASE:  prdata = CFG_DW'(r_icase);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.pattern     = {r_pat_hi, r_pat_lo};
    assign o_cfg.length      = r_len;
    assign o_cfg.ignore_case = r_icase;

endmodule

>>> design/substring_first_match_finder.sv
// Top level of the streaming first-match substring finder.
//
// Streams a buffer in one byte per request (tlast on the final byte) and,
// in the cycle after the final byte is taken, gives one result request:
// found, the start index of the first occurrence of the configured pattern
// (0 when not found, saturating at 65535) and a too_long flag for buffers
// longer than MAX_BUFFER_BYTES (bytes beyond the limit are dropped, their
// tlast still ends the buffer). A row of MAX_PATTERN_BYTES cells forms the
// sliding window; each cell compares its new byte against one pattern byte
// in the cycle the byte arrives, so throughput is one byte per clock. The
// only stall is a final byte arriving while the previous result has not
// yet been taken downstream. An empty pattern always reports found at 0.
// With ignore_case set, a-z fold to A-Z on both sides before comparing.
// Pattern and case settings are written over APB while no buffer is in
// flight: 0x00 pattern bytes 0-7, 0x08 bytes 8-15, 0x10 length, 0x18
// ignore_case (reset 1).
module substring_first_match_finder
    import sfmf_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int MAX_BUFFER_BYTES  = DEF_MAX_BUFFER_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [CFG_DW-1:0]      pwdata,
    output logic [CFG_DW-1:0]      prdata,
    output logic                   pready,
    // byte stream in
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [DATA_W-1:0]      i_s_tdata,   // [7:0] data_byte
    input  logic                   i_s_tlast,   // last_byte
    // result out
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [0] found, [16:1] match_position,
                                                // [17] too_long, [23:18] zero
);

`include "substring_first_match_finder_macros.svh"

    localparam int CNT_W   = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int PW      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEN_CAP = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;

    t_cfg w_cfg;

    sfmf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------- per-buffer state ----------------
    logic [CNT_W-1:0] r_count;
    logic             r_match;
    logic [POS_W-1:0] r_first_pos;
    logic             r_ovf;
    logic             r_out_valid;
    logic             r_out_found;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_long;

    logic [CNT_W-1:0] n_count;
    logic             n_match;
    logic [POS_W-1:0] n_first_pos;
    logic             n_ovf;

    logic             w_in_acc;
    logic             w_full;
    logic             w_shift;
    logic [LEN_W-1:0] w_len;
    logic             w_align_hit;
    logic [CNT_W-1:0] w_pos;
    logic [PW-1:0]    w_pos_wide;
    logic [POS_W-1:0] w_pos_sat;

    // A non-final byte never produces a result, so it is taken even while
    // the output register is still waiting.
    assign o_s_tready = !r_out_valid || i_m_tready || !i_s_tlast;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(MAX_BUFFER_BYTES));
    assign w_shift    = w_in_acc && !w_full;

    // length in use, capped at the window size
    assign w_len = (w_cfg.length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : w_cfg.length;

    // ---------------- window cell row ----------------
    // cell k holds window byte k (0 = newest) and checks pattern byte len-1-k
    logic [DATA_W-1:0] w_pat  [PAT_BYTES];
    logic [DATA_W-1:0] w_link [MAX_PATTERN_BYTES+1];
    logic [MAX_PATTERN_BYTES-1:0] w_hit;

    for (genvar p = 0; p < PAT_BYTES; p++) begin : g_pat
        assign w_pat[p] = w_cfg.pattern[p*DATA_W +: DATA_W];
    end

    assign w_link[0] = i_s_tdata;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        logic              w_active;
        logic [3:0]        w_idx;
        logic [DATA_W-1:0] w_expect;

        assign w_active = (k < int'(w_len));
        assign w_idx    = 4'(int'(w_len) - 1 - k);
        assign w_expect = fold_byte(w_pat[w_idx], w_cfg.ignore_case);

        sfmf_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_shift),
            .i_byte   (w_link[k]),
            .i_expect (w_expect),
            .i_active (w_active),
            .i_fold   (w_cfg.ignore_case),
            .o_byte   (w_link[k+1]),
            .o_hit    (w_hit[k])
        );
    end

    // ---------------- alignment check and state update ----------------
    always_comb begin
        n_count     = r_count;
        n_match     = r_match;
        n_first_pos = r_first_pos;
        n_ovf       = r_ovf;
        if (w_in_acc) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
        w_align_hit = w_shift && !r_match && (w_len != '0)
                      && (n_count >= CNT_W'(w_len)) && (&w_hit);
        w_pos      = n_count - CNT_W'(w_len);
        w_pos_wide = PW'(w_pos);
        w_pos_sat  = (w_pos_wide > PW'(16'hFFFF)) ? 16'hFFFF : w_pos_wide[POS_W-1:0];
        if (w_align_hit) begin
            n_match     = 1'b1;
            n_first_pos = w_pos_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_match     <= 1'b0;
            r_first_pos <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc && i_s_tlast) begin
                // close out the buffer
                r_count     <= '0;
                r_match     <= 1'b0;
                r_first_pos <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                r_count     <= n_count;
                r_match     <= n_match;
                r_first_pos <= n_first_pos;
                r_ovf       <= n_ovf;
                if (i_m_tready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // result payload, loaded with the final byte
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_s_tlast) begin
            if (w_len == '0) begin
                r_out_found <= 1'b1;
                r_out_pos   <= '0;
            end else begin
                r_out_found <= n_match;
                r_out_pos   <= n_match ? n_first_pos : '0;
            end
            r_out_long <= n_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_long, r_out_pos, r_out_found};

    // ---------------- checks ----------------
    `SFMF_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_BUFFER_BYTES), "byte count above limit")
    `SFMF_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, r_ovf, w_full,
        "overflow flagged before the limit was reached")
    `SFMF_ASSERT_NOW(a_match_count, i_clk, i_rst_n, r_match,
        (r_count != '0) && (PW'(r_first_pos) <= PW'(r_count)),
        "match position beyond bytes seen")
    `SFMF_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, w_in_acc && i_s_tlast,
        o_m_tvalid && (r_count == '0) && !r_match && !r_ovf,
        "final byte did not close the buffer")

endmodule

>>> tb/sv/search_result_checker.sv
// Checker for the substring finder: tracks config writes, predicts each result and compares.
module search_result_checker
    import sfmf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [CFG_DW-1:0]      pwdata,
    input  logic                   pready,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [DATA_W-1:0]      i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_mismatches,
    output int                     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = DEF_MAX_PATTERN_BYTES;
    localparam int LIMIT_BYTES = DEF_MAX_BUFFER_BYTES;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             too_long;
    } t_search_answer;

    // shadow of the config registers
    logic [PAT_BYTES*DATA_W-1:0] pattern;
    logic [LEN_W-1:0]            pattern_len;
    logic                        nocase;

    // per-buffer search state
    logic [DATA_W-1:0] window [WINDOW];
    int unsigned       bytes_taken;
    logic              hit;
    logic [POS_W-1:0]  hit_pos;
    logic              overflow;

    t_search_answer expected_answers[$];

    function automatic logic [DATA_W-1:0] upcase(input logic [DATA_W-1:0] c);
        if (nocase && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    task automatic clear_search();
        foreach (window[k]) begin
            window[k] = '0;
        end
        bytes_taken = 0;
        hit         = 1'b0;
        hit_pos     = '0;
        overflow    = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    // One accepted byte: slide the window, test the alignment it completes,
    // and on the final byte queue the answer for the whole buffer.
    task automatic search_byte(input logic [DATA_W-1:0] b, input logic last);
        int unsigned    len;
        int unsigned    pos;
        logic           equal;
        t_search_answer ans;
        len = (pattern_len > PAT_BYTES) ? PAT_BYTES : pattern_len;
        if (len > WINDOW) begin
            len = WINDOW;
        end
        if (bytes_taken >= LIMIT_BYTES) begin
            overflow = 1'b1;    // beyond the limit: byte dropped
        end else begin
            for (int k = WINDOW - 1; k > 0; k--) begin
                window[k] = window[k-1];
            end
            window[0] = b;
            bytes_taken++;
            if (!hit && len > 0 && bytes_taken >= len) begin
                equal = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (upcase(pattern[8*i +: 8]) != upcase(window[len-1-i])) begin
                        equal = 1'b0;
                    end
                end
                if (equal) begin
                    pos     = bytes_taken - len;
                    hit     = 1'b1;
                    hit_pos = (pos > 32'hFFFF) ? 16'hFFFF : pos[POS_W-1:0];
                end
            end
        end
        if (last) begin
            ans.found    = (len == 0) ? 1'b1 : hit;
            ans.position = (len == 0 || !hit) ? '0 : hit_pos;
            ans.too_long = overflow;
            expected_answers.push_back(ans);
            clear_search();
        end
    endtask

    always @(posedge i_clk) begin
        t_search_answer want;
        if (!i_rst_n) begin
            pattern     = '0;
            pattern_len = '0;
            nocase      = 1'b1;
            clear_search();
            expected_answers.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[CFG_AW-1:3]))
                    REG_PATTERN_LOW:  pattern[63:0]   = pwdata;
                    REG_PATTERN_HIGH: pattern[127:64] = pwdata;
                    REG_PATTERN_LEN:  pattern_len     = pwdata[LEN_W-1:0];
                    REG_IGNORE_CASE:  nocase          = pwdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                search_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("result with none pending, tdata=%h", i_m_tdata));
                end else begin
                    want = expected_answers.pop_front();
                    if (i_m_tdata[0] !== want.found) begin
                        report_mismatch($sformatf("found exp %0b got %0b",
                                                  want.found, i_m_tdata[0]));
                    end
                    if (i_m_tdata[16:1] !== want.position) begin
                        report_mismatch($sformatf("match_position exp %0d got %0d",
                                                  want.position, i_m_tdata[16:1]));
                    end
                    if (i_m_tdata[17] !== want.too_long) begin
                        report_mismatch($sformatf("too_long exp %0b got %0b",
                                                  want.too_long, i_m_tdata[17]));
                    end
                end
            end
        end
        o_outstanding = expected_answers.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the substring finder: clock, reset, stimulus and verdict.
module tb_top;
    import sfmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 100_000;    // cycles
    localparam int DRAIN       = 8;          // result shows in the cycle after tlast is taken
    localparam int HOLD_CYCLES = 300;        // long output back-pressure stretch

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [CFG_AW-1:0]      paddr      = '0;
    logic [CFG_DW-1:0]      pwdata     = '0;
    logic [CFG_DW-1:0]      prdata;
    logic                   pready;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [DATA_W-1:0]      i_s_tdata  = '0;    // [7:0] data_byte
    logic                   i_s_tlast  = 1'b0;  // last_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // [0] found, [16:1] match_position,
                                                // [17] too_long

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // stimulus knobs shared with the receiver process
    logic idling     = 1'b1;
    logic hold_start = 1'b0;
    int   hold_left  = 0;

    logic [DATA_W-1:0] pat_bytes [PAT_BYTES];
    logic [DATA_W-1:0] frame[$];

    substring_first_match_finder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    search_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result receiver. Normally drops tready ~25% of cycles; a hold request
    // parks it low for a long stretch so the block backs up into its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_start && hold_left == 0) begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (idling) begin
                i_m_tready <= ($urandom_range(99) >= 25);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // APB write: setup cycle, then access cycle held until pready.
    // psel/penable are dropped by the caller once the burst of writes is done.
    task automatic cfg_write(input t_reg_idx idx, input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Writes every register from pat_bytes and the given length / case mode.
    task automatic apply_config(input int len_value, input logic nocase);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = pat_bytes[i];
            hi[8*i +: 8] = pat_bytes[i+8];
        end
        cfg_write(REG_PATTERN_LOW, lo);
        cfg_write(REG_PATTERN_HIGH, hi);
        cfg_write(REG_PATTERN_LEN, CFG_DW'(len_value));
        cfg_write(REG_IGNORE_CASE, CFG_DW'(nocase));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One byte request; tvalid is left high so back-to-back bytes need no gap.
    task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
        while (idling && $urandom_range(99) < 25) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_frame();
        foreach (frame[i]) begin
            send_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    // Stop offering, let every pending result land, then wait out DRAIN.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        repeat (2) @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic load_text(input string s);
        frame.delete();
        for (int i = 0; i < s.len(); i++) begin
            frame.push_back(s[i]);
        end
    endtask

    task automatic load_pattern(input string s);
        foreach (pat_bytes[i]) begin
            pat_bytes[i] = (i < s.len()) ? s[i] : 8'h00;
        end
    endtask

    // Letters flip case half the time; everything else passes.
    function automatic logic [DATA_W-1:0] maybe_flip(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] low;
        low = c | CASE_OFFSET;
        if (low >= CHAR_LOWER_A && low <= CHAR_LOWER_Z && $urandom_range(1) == 1) begin
            return c ^ CASE_OFFSET;
        end
        return c;
    endfunction

    // Small alphabet plus pattern bytes so partial matches are common.
    function automatic logic [DATA_W-1:0] noise_byte();
        case ($urandom_range(3))
            0:       return pat_bytes[$urandom_range(PAT_BYTES - 1)];
            1:       return maybe_flip(CHAR_LOWER_A + DATA_W'($urandom_range(2)));
            default: return DATA_W'($urandom_range(255));
        endcase
    endfunction

    // Random buffer; often carries the pattern (case-scrambled), sometimes
    // a copy with one byte broken as a near miss.
    task automatic random_frame(input int size, input int len_value);
        int used;
        int at;
        used = (len_value > PAT_BYTES) ? PAT_BYTES : len_value;
        frame.delete();
        for (int i = 0; i < size; i++) begin
            frame.push_back(noise_byte());
        end
        if (used > 0 && used <= size && $urandom_range(99) < 70) begin
            at = $urandom_range(size - used);
            for (int j = 0; j < used; j++) begin
                frame[at+j] = maybe_flip(pat_bytes[j]);
            end
            if ($urandom_range(99) < 30) begin
                frame[at + $urandom_range(used - 1)] = DATA_W'($urandom_range(255));
            end
        end
    endtask

    initial begin
        int lens [10];
        int len_value;
        int sent;
        int size;

        lens = '{1, 16, 0, 31, 2, 3, 5, 8, 12, 17};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // ---- directed ----
        // Reset config: empty pattern, found at 0.
        load_text("z");
        send_frame();
        settle();

        // Case-insensitive "hello": hit at 1, then a buffer shorter than the pattern.
        load_pattern("hello");
        apply_config(5, 1'b1);
        load_text("xHeLLo");
        send_frame();
        load_text("hel");
        send_frame();
        settle();

        // Exact case: only the lower-case copy matches.
        apply_config(5, 1'b0);
        load_text("aHELLOhello");
        send_frame();
        settle();

        // Length register above 16 saturates; pattern carries 00/FF and the
        // characters right next to the letter ranges, which must not fold.
        pat_bytes = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h71, 8'h52,
                      8'h73, 8'h54, 8'h75, 8'h56, 8'h77, 8'h58, 8'h79, 8'h5A};
        apply_config(31, 1'b1);
        frame.delete();
        foreach (pat_bytes[i]) begin
            frame.push_back(maybe_flip(pat_bytes[i]));
        end
        send_frame();
        settle();

        // ---- random phases ----
        for (int ph = 0; ph < 10; ph++) begin
            foreach (pat_bytes[i]) begin
                pat_bytes[i] = ($urandom_range(3) == 0)
                               ? DATA_W'($urandom_range(255))
                               : maybe_flip(CHAR_LOWER_A + DATA_W'($urandom_range(2)));
            end
            len_value = lens[ph];
            apply_config(len_value, 1'($urandom_range(1)));
            idling = (ph != 3);   // one phase runs flat out on both sides

            if (ph == 6) begin
                // Receiver stalls for a long stretch while short buffers keep
                // coming, so the result slot fills and the input backs up.
                hold_start = 1'b1;
                for (int f = 0; f < 60; f++) begin
                    random_frame($urandom_range(1, 3), len_value);
                    send_frame();
                end
            end

            sent = 0;
            while (sent < 130) begin
                size = ($urandom_range(9) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 20);
                random_frame(size, len_value);
                send_frame();
                sent += size;
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
